### hdl/nuct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nuct_pkg: shared types and constants for the nibble unpack corner turn
// Holds field widths, count limits, register indexes, reset values of the
// stride registers and the result item layout.
// ----------------------------------------------------------------------------
package nuct_pkg;

    // Count limits and address range.
    localparam int MAX_ANTENNAS  = 256;
    localparam int MAX_CHANNELS  = 1024;
    localparam int MAX_STEPS     = 65535;
    localparam int ADDR_BITS     = 32;
    localparam int POLARIZATIONS = 2;

    // Configuration register widths.
    localparam int A_CNT_W  = 9;
    localparam int C_CNT_W  = 11;
    localparam int S_CNT_W  = 16;
    localparam int EDGE_W   = 10;
    localparam int CFG_DW   = 16;
    localparam int CFG_AW   = 8;

    // Counter widths.
    localparam int ANT_IDX_W  = 8;
    localparam int CHAN_IDX_W = 10;
    localparam int STEP_W     = 16;

    // Address term widths.
    localparam int BASE_W        = 33;
    localparam int ANT_STRIDE_W  = 17;  // 2*S
    localparam int CHAN_STRIDE_W = 25;  // 2*S*A
    localparam int P_SC_W        = 27;  // 2*S*C
    localparam int P_AC_W        = 19;  // A*C
    localparam int INT_STRIDE_W  = 35;  // 2*S*A*C
    localparam int SUM_W         = 36;
    localparam int OUT_ADDR_W    = 32;

    localparam logic [BASE_W-1:0] BASE_MAX = {BASE_W{1'b1}};

    // Reset values of the counts and of the products derived from them.
    localparam int RST_A = 128;
    localparam int RST_C = 128;
    localparam int RST_S = 1;
    localparam int RST_ANT_STRIDE  = POLARIZATIONS * RST_S;
    localparam int RST_CHAN_STRIDE = POLARIZATIONS * RST_S * RST_A;
    localparam int RST_P_SC        = POLARIZATIONS * RST_S * RST_C;
    localparam int RST_P_AC        = RST_A * RST_C;
    localparam int RST_INT_STRIDE  = POLARIZATIONS * RST_S * RST_A * RST_C;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_ANTENNA_COUNT     = 8'd0;
    localparam logic [CFG_AW-1:0] CFG_CHANNEL_COUNT     = 8'd1;
    localparam logic [CFG_AW-1:0] CFG_INTEGRATION_STEPS = 8'd2;
    localparam logic [CFG_AW-1:0] CFG_EDGE_CHANNELS     = 8'd3;

    // Stream widths.
    localparam int IN_DW  = 16;
    localparam int OUT_DW = 88;

    // One result item.
    typedef struct packed {
        logic               address_overflow;
        logic signed [3:0]  imag_pol1;
        logic signed [3:0]  real_pol1;
        logic signed [3:0]  imag_pol0;
        logic signed [3:0]  real_pol0;
        logic [OUT_ADDR_W-1:0] address_pol1;
        logic [OUT_ADDR_W-1:0] address_pol0;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // Effective counts: zero acts as one, large values stop at the limit.
    function automatic logic [A_CNT_W-1:0] clamp_antennas(input logic [A_CNT_W-1:0] v);
        if (v == '0) begin
            return A_CNT_W'(1);
        end else if (int'(v) > MAX_ANTENNAS) begin
            return A_CNT_W'(MAX_ANTENNAS);
        end
        return v;
    endfunction

    function automatic logic [C_CNT_W-1:0] clamp_channels(input logic [C_CNT_W-1:0] v);
        if (v == '0) begin
            return C_CNT_W'(1);
        end else if (int'(v) > MAX_CHANNELS) begin
            return C_CNT_W'(MAX_CHANNELS);
        end
        return v;
    endfunction

    function automatic logic [S_CNT_W-1:0] clamp_steps(input logic [S_CNT_W-1:0] v);
        if (v == '0) begin
            return S_CNT_W'(1);
        end else if (int'(v) > MAX_STEPS) begin
            return S_CNT_W'(MAX_STEPS);
        end
        return v;
    endfunction

endpackage
`default_nettype wire

### hdl/nibble_unpack_corner_turn.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nibble_unpack_corner_turn: 4-bit complex unpacking with corner-turn addresses
// Every input item is one antenna's dual-polarization sample. Each produces one
// result item with the two signed 4-bit complex samples (zeroed in band-edge
// channels), their destination indices and a sticky address overflow flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata, antenna fastest, then
//   channel, then timestep. Result items leave on m_tvalid/m_tready/m_tdata.
//   An accepted item reaches m_tvalid through the output register, or under a
//   stall through the skid register. Throughput is one item per cycle while
//   the receiver does not stall, and a skid register keeps s_tready registered.
//   When the receiver stalls, one more item is taken into the skid register,
//   then s_tready drops until the output register drains.
//   Counts and edge width are written through cfg_wr_en/cfg_addr/cfg_wdata
//   while the stream is idle; the stride products are updated on the same
//   edge, so an item may follow in the next cycle.
//   Reset (aresetn low, synchronous) restores the default counts, clears all
//   counters, bases and the overflow flag, and empties both output registers.
// ----------------------------------------------------------------------------
module nibble_unpack_corner_turn (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // Input items: [15:0] raw_word
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [nuct_pkg::IN_DW-1:0]   s_tdata,
    // Result items: [31:0] address_pol0, [63:32] address_pol1, [67:64] real_pol0,
    // [71:68] imag_pol0, [75:72] real_pol1, [79:76] imag_pol1,
    // [80] address_overflow, [87:81] zero
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [nuct_pkg::OUT_DW-1:0]       m_tdata,
    // Configuration writes
    input  wire logic                         cfg_wr_en,
    input  wire logic [nuct_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic [nuct_pkg::CFG_DW-1:0]  cfg_wdata
);

    // Effective counts and edge width.
    logic [nuct_pkg::A_CNT_W-1:0] a_cnt_reg, a_cnt_next;
    logic [nuct_pkg::C_CNT_W-1:0] c_cnt_reg, c_cnt_next;
    logic [nuct_pkg::S_CNT_W-1:0] s_cnt_reg, s_cnt_next;
    logic [nuct_pkg::EDGE_W-1:0]  edge_reg, edge_next;

    // Stride products, kept current on every configuration write.
    logic [nuct_pkg::ANT_STRIDE_W-1:0]  ant_stride_reg, ant_stride_next;
    logic [nuct_pkg::CHAN_STRIDE_W-1:0] chan_stride_reg, chan_stride_next;
    logic [nuct_pkg::P_SC_W-1:0]        p_sc_reg, p_sc_next;
    logic [nuct_pkg::P_AC_W-1:0]        p_ac_reg, p_ac_next;
    logic [nuct_pkg::INT_STRIDE_W-1:0]  int_stride_reg, int_stride_next;

    // Position counters and running address terms.
    logic [nuct_pkg::ANT_IDX_W-1:0]  antenna_index_reg, antenna_index_next;
    logic [nuct_pkg::CHAN_IDX_W-1:0] channel_index_reg, channel_index_next;
    logic [nuct_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [nuct_pkg::BASE_W-1:0]     interval_base_reg, interval_base_next;
    logic [nuct_pkg::BASE_W-1:0]     channel_base_reg, channel_base_next;
    logic [nuct_pkg::BASE_W-1:0]     antenna_offset_reg, antenna_offset_next;
    logic                            overflow_seen_reg, overflow_seen_next;

    // Output and skid registers.
    nuct_pkg::result_t out_reg, out_next;
    nuct_pkg::result_t skid_reg, skid_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              skid_valid_reg, skid_valid_next;

    logic              accept;
    nuct_pkg::result_t result;

    logic [nuct_pkg::A_CNT_W-1:0] a_new;
    logic [nuct_pkg::C_CNT_W-1:0] c_new;
    logic [nuct_pkg::S_CNT_W-1:0] s_new;
    logic [nuct_pkg::ANT_STRIDE_W-1:0] s2_new;

    logic [nuct_pkg::SUM_W-1:0]  addr0, addr1;
    logic                        addr_ovf;
    logic                        edge_chan;
    logic [nuct_pkg::C_CNT_W-1:0] chan_plus_edge;
    logic                        ant_wrap, chan_wrap, step_wrap;
    logic [nuct_pkg::BASE_W:0]   sat_ant, sat_chan, sat_int;

    // Saturating add of a base term: returns {overflow, value}.
    function automatic logic [nuct_pkg::BASE_W:0] sat_add(
        input logic [nuct_pkg::BASE_W-1:0]       a,
        input logic [nuct_pkg::INT_STRIDE_W-1:0] b
    );
        logic [nuct_pkg::SUM_W-1:0] s;
        s = nuct_pkg::SUM_W'(a) + nuct_pkg::SUM_W'(b);
        if (s > nuct_pkg::SUM_W'(nuct_pkg::BASE_MAX)) begin
            return {1'b1, nuct_pkg::BASE_MAX};
        end
        return {1'b0, s[nuct_pkg::BASE_W-1:0]};
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = nuct_pkg::OUT_DW'(out_reg);

    // Configuration writes: each updates its count and every product using it.
    always_comb begin
        a_new  = nuct_pkg::clamp_antennas(cfg_wdata[nuct_pkg::A_CNT_W-1:0]);
        c_new  = nuct_pkg::clamp_channels(cfg_wdata[nuct_pkg::C_CNT_W-1:0]);
        s_new  = nuct_pkg::clamp_steps(cfg_wdata[nuct_pkg::S_CNT_W-1:0]);
        s2_new = {s_new, 1'b0};

        a_cnt_next       = a_cnt_reg;
        c_cnt_next       = c_cnt_reg;
        s_cnt_next       = s_cnt_reg;
        edge_next        = edge_reg;
        ant_stride_next  = ant_stride_reg;
        chan_stride_next = chan_stride_reg;
        p_sc_next        = p_sc_reg;
        p_ac_next        = p_ac_reg;
        int_stride_next  = int_stride_reg;

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                nuct_pkg::CFG_ANTENNA_COUNT: begin
                    a_cnt_next       = a_new;
                    chan_stride_next = nuct_pkg::CHAN_STRIDE_W'(ant_stride_reg)
                                     * nuct_pkg::CHAN_STRIDE_W'(a_new);
                    p_ac_next        = nuct_pkg::P_AC_W'(a_new)
                                     * nuct_pkg::P_AC_W'(c_cnt_reg);
                    int_stride_next  = nuct_pkg::INT_STRIDE_W'(p_sc_reg)
                                     * nuct_pkg::INT_STRIDE_W'(a_new);
                end
                nuct_pkg::CFG_CHANNEL_COUNT: begin
                    c_cnt_next      = c_new;
                    p_sc_next       = nuct_pkg::P_SC_W'(ant_stride_reg)
                                    * nuct_pkg::P_SC_W'(c_new);
                    p_ac_next       = nuct_pkg::P_AC_W'(a_cnt_reg)
                                    * nuct_pkg::P_AC_W'(c_new);
                    int_stride_next = nuct_pkg::INT_STRIDE_W'(chan_stride_reg)
                                    * nuct_pkg::INT_STRIDE_W'(c_new);
                end
                nuct_pkg::CFG_INTEGRATION_STEPS: begin
                    s_cnt_next       = s_new;
                    ant_stride_next  = s2_new;
                    chan_stride_next = nuct_pkg::CHAN_STRIDE_W'(s2_new)
                                     * nuct_pkg::CHAN_STRIDE_W'(a_cnt_reg);
                    p_sc_next        = nuct_pkg::P_SC_W'(s2_new)
                                     * nuct_pkg::P_SC_W'(c_cnt_reg);
                    int_stride_next  = nuct_pkg::INT_STRIDE_W'(s2_new)
                                     * nuct_pkg::INT_STRIDE_W'(p_ac_reg);
                end
                nuct_pkg::CFG_EDGE_CHANNELS: begin
                    edge_next = cfg_wdata[nuct_pkg::EDGE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Result of the item at the input: addresses, edge zeroing, overflow flag.
    always_comb begin
        addr0 = nuct_pkg::SUM_W'(interval_base_reg) + nuct_pkg::SUM_W'(channel_base_reg)
              + nuct_pkg::SUM_W'(antenna_offset_reg) + nuct_pkg::SUM_W'(step_reg);
        addr1 = addr0 + nuct_pkg::SUM_W'(s_cnt_reg);
        // addr1 is always above addr0, so it alone decides overflow.
        addr_ovf = |addr1[nuct_pkg::SUM_W-1:nuct_pkg::ADDR_BITS];

        chan_plus_edge = nuct_pkg::C_CNT_W'(channel_index_reg)
                       + nuct_pkg::C_CNT_W'(edge_reg);
        edge_chan = (channel_index_reg < edge_reg) || (chan_plus_edge >= c_cnt_reg);

        result.address_pol0     = addr0[nuct_pkg::OUT_ADDR_W-1:0];
        result.address_pol1     = addr1[nuct_pkg::OUT_ADDR_W-1:0];
        result.real_pol0        = edge_chan ? 4'sd0 : $signed(s_tdata[3:0]);
        result.imag_pol0        = edge_chan ? 4'sd0 : $signed(s_tdata[7:4]);
        result.real_pol1        = edge_chan ? 4'sd0 : $signed(s_tdata[11:8]);
        result.imag_pol1        = edge_chan ? 4'sd0 : $signed(s_tdata[15:12]);
        result.address_overflow = overflow_seen_reg || addr_ovf;
    end

    // Counter advance: antenna, then channel, then timestep.
    always_comb begin
        ant_wrap  = (nuct_pkg::A_CNT_W'(antenna_index_reg) + 1'b1) >= a_cnt_reg;
        chan_wrap = (nuct_pkg::C_CNT_W'(channel_index_reg) + 1'b1) >= c_cnt_reg;
        step_wrap = ({1'b0, step_reg} + 1'b1) >= {1'b0, s_cnt_reg};

        sat_ant  = sat_add(antenna_offset_reg, nuct_pkg::INT_STRIDE_W'(ant_stride_reg));
        sat_chan = sat_add(channel_base_reg, nuct_pkg::INT_STRIDE_W'(chan_stride_reg));
        sat_int  = sat_add(interval_base_reg, int_stride_reg);

        antenna_index_next  = antenna_index_reg;
        channel_index_next  = channel_index_reg;
        step_next           = step_reg;
        interval_base_next  = interval_base_reg;
        channel_base_next   = channel_base_reg;
        antenna_offset_next = antenna_offset_reg;
        overflow_seen_next  = overflow_seen_reg;

        if (accept) begin
            overflow_seen_next = result.address_overflow;
            if (ant_wrap) begin
                antenna_index_next  = '0;
                antenna_offset_next = '0;
                if (chan_wrap) begin
                    channel_index_next = '0;
                    channel_base_next  = '0;
                    if (step_wrap) begin
                        step_next          = '0;
                        interval_base_next = sat_int[nuct_pkg::BASE_W-1:0];
                        overflow_seen_next = result.address_overflow
                                           || sat_int[nuct_pkg::BASE_W];
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end else begin
                    channel_index_next = channel_index_reg + 1'b1;
                    channel_base_next  = sat_chan[nuct_pkg::BASE_W-1:0];
                    overflow_seen_next = result.address_overflow
                                       || sat_chan[nuct_pkg::BASE_W];
                end
            end else begin
                antenna_index_next  = antenna_index_reg + 1'b1;
                antenna_offset_next = sat_ant[nuct_pkg::BASE_W-1:0];
                overflow_seen_next  = result.address_overflow
                                    || sat_ant[nuct_pkg::BASE_W];
            end
        end
    end

    // Output register with a skid stage behind it.
    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        m_tvalid_next   = m_tvalid_reg;
        skid_valid_next = skid_valid_reg;

        if (!m_tvalid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
                m_tvalid_next   = 1'b1;
            end else begin
                out_next      = result;
                m_tvalid_next = accept;
            end
        end else if (accept) begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_cnt_reg          <= nuct_pkg::A_CNT_W'(nuct_pkg::RST_A);
            c_cnt_reg          <= nuct_pkg::C_CNT_W'(nuct_pkg::RST_C);
            s_cnt_reg          <= nuct_pkg::S_CNT_W'(nuct_pkg::RST_S);
            edge_reg           <= '0;
            ant_stride_reg     <= nuct_pkg::ANT_STRIDE_W'(nuct_pkg::RST_ANT_STRIDE);
            chan_stride_reg    <= nuct_pkg::CHAN_STRIDE_W'(nuct_pkg::RST_CHAN_STRIDE);
            p_sc_reg           <= nuct_pkg::P_SC_W'(nuct_pkg::RST_P_SC);
            p_ac_reg           <= nuct_pkg::P_AC_W'(nuct_pkg::RST_P_AC);
            int_stride_reg     <= nuct_pkg::INT_STRIDE_W'(nuct_pkg::RST_INT_STRIDE);
            antenna_index_reg  <= '0;
            channel_index_reg  <= '0;
            step_reg           <= '0;
            interval_base_reg  <= '0;
            channel_base_reg   <= '0;
            antenna_offset_reg <= '0;
            overflow_seen_reg  <= 1'b0;
            m_tvalid_reg       <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end else begin
            a_cnt_reg          <= a_cnt_next;
            c_cnt_reg          <= c_cnt_next;
            s_cnt_reg          <= s_cnt_next;
            edge_reg           <= edge_next;
            ant_stride_reg     <= ant_stride_next;
            chan_stride_reg    <= chan_stride_next;
            p_sc_reg           <= p_sc_next;
            p_ac_reg           <= p_ac_next;
            int_stride_reg     <= int_stride_next;
            antenna_index_reg  <= antenna_index_next;
            channel_index_reg  <= channel_index_next;
            step_reg           <= step_next;
            interval_base_reg  <= interval_base_next;
            channel_base_reg   <= channel_base_next;
            antenna_offset_reg <= antenna_offset_next;
            overflow_seen_reg  <= overflow_seen_next;
            m_tvalid_reg       <= m_tvalid_next;
            skid_valid_reg     <= skid_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

`ifndef SYNTHESIS
    // The skid register only fills behind a full output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_tvalid_reg)
        else $error("skid register holds an item while the output is empty");

    // An item accepted against a stalled output lands in the skid register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && m_tvalid_reg && !m_tready) |=> skid_valid_reg)
        else $error("item accepted under stall was dropped");

    // The overflow flag is sticky until reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_seen_reg |=> overflow_seen_reg)
        else $error("overflow flag cleared without reset");

    // Wrapped counters always restart their address terms at zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (antenna_index_reg == '0) |-> (antenna_offset_reg == '0))
        else $error("antenna offset not zero at first antenna");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (channel_index_reg == '0) |-> (channel_base_reg == '0))
        else $error("channel base not zero at first channel");
`endif

endmodule
`default_nettype wire
